[src/lsad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsad_pkg
// Shared types and constants for the LIFO stack with alternate drop.
// ----------------------------------------------------------------------------
package lsad_pkg;

    // Payload widths fixed by the item format
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 11;

    // Action codes carried by each input item
    typedef enum logic [1:0] {
        ACT_PUSH     = 2'd0,
        ACT_POP      = 2'd1,
        ACT_DROP_TOP = 2'd2,
        ACT_KEEP_TOP = 2'd3
    } t_action;

    // One result item
    typedef struct packed {
        logic [WORD_W-1:0]  popped_value;
        logic [COUNT_W-1:0] element_count;
        logic               empty_error;
        logic               full_error;
    } t_result;

endpackage
`default_nettype wire

[src/lsad_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsad_in_if
// Input channel: one action with its push word per transfer.
// ----------------------------------------------------------------------------
interface lsad_in_if import lsad_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_action                  action;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface
`default_nettype wire

[src/lsad_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsad_out_if
// Output channel: one result per transfer.
// ----------------------------------------------------------------------------
interface lsad_out_if import lsad_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] popped_value;
    logic [COUNT_W-1:0]       element_count;
    logic                     empty_error;
    logic                     full_error;

    modport source (output valid, output popped_value, output element_count,
                    output empty_error, output full_error, input ready);
    modport sink   (input valid, input popped_value, input element_count,
                    input empty_error, input full_error, output ready);
endinterface
`default_nettype wire

[src/lsad_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsad_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lsad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[src/lsad_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsad_core
// Sequencer and address unit: push, pop and the compaction walk over the RAM.
// ----------------------------------------------------------------------------
module lsad_core import lsad_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    lsad_in_if.sink                i_in,
    // result toward the output register
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res,
    // RAM ports
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output logic [WORD_W-1:0]      o_wr_data,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_rd_addr,
    input  wire logic [WORD_W-1:0] i_rd_data
);

    localparam int             CW      = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_COMP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                r_st, n_st;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_n, n_n;
    logic [CW:0]           r_rd, n_rd;
    logic [CW-1:0]         r_wr, n_wr;
    logic                  r_pend, n_pend;
    logic [WORD_W-1:0]     r_popped, n_popped;
    logic                  r_empty, n_empty;
    logic                  r_full, n_full;

    logic [CW-1:0]         cnt_dec;
    logic                  issue;
    logic                  in_xfer;
    logic [CW+COUNT_W-1:0] count_ext;

    assign cnt_dec = r_count - 1'b1;
    assign issue   = (r_rd < {1'b0, r_n});
    assign in_xfer = i_in.valid && i_in.ready;

    // Sequencer
    always_comb begin
        n_st       = r_st;
        n_count    = r_count;
        n_n        = r_n;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_pend     = r_pend;
        n_popped   = r_popped;
        n_empty    = r_empty;
        n_full     = r_full;
        i_in.ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[AW-1:0];
        o_wr_data  = i_in.push_value;
        o_rd_en    = 1'b0;
        o_rd_addr  = cnt_dec[AW-1:0];

        case (r_st)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_popped = '0;
                    n_empty  = 1'b0;
                    n_full   = 1'b0;
                    case (i_in.action)
                        ACT_PUSH: begin
                            n_st = S_DONE;
                            if (r_count >= DEPTH_C) begin
                                n_full = 1'b1;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_empty = 1'b1;
                                n_st    = S_DONE;
                            end else begin
                                o_rd_en = 1'b1;
                                n_count = cnt_dec;
                                n_st    = S_POP;
                            end
                        end
                        default: begin
                            // Compaction: first kept slot from the bottom, then stride two
                            n_n    = r_count;
                            n_rd   = {{CW{1'b0}},
                                      cnt_dec[0] ^ (i_in.action == ACT_DROP_TOP)};
                            n_wr   = '0;
                            n_pend = 1'b0;
                            n_st   = (r_count == '0) ? S_DONE : S_COMP;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped = i_rd_data;
                n_st     = S_DONE;
            end
            S_COMP: begin
                // Read the next kept word
                if (issue) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_rd[AW-1:0];
                    n_rd      = r_rd + (CW+1)'(2);
                end
                n_pend = issue;
                // Write back the word read last cycle
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_wr[AW-1:0];
                    o_wr_data = i_rd_data;
                    n_wr      = r_wr + 1'b1;
                end
                if (!issue && !r_pend) begin
                    n_count = r_wr;
                    n_st    = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Walk pointers and result fields
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_popped <= n_popped;
        r_empty  <= n_empty;
        r_full   <= n_full;
    end

    // Result assembly; count reported modulo its field width
    assign count_ext               = {{COUNT_W{1'b0}}, r_count};
    assign o_res.popped_value      = r_popped;
    assign o_res.element_count     = count_ext[COUNT_W-1:0];
    assign o_res.empty_error       = r_empty;
    assign o_res.full_error        = r_full;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count above depth");

    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_COMP) |-> ({1'b0, r_wr} <= r_rd))
        else $error("compaction write pointer passed read pointer");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.action == ACT_PUSH && r_count < DEPTH_C)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push with room did not grow the stack");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_in.ready)
        else $error("input accepted while an item is in progress");

endmodule
`default_nettype wire

[src/lifo_stack_with_alternate_drop.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_with_alternate_drop
// LIFO of signed 32-bit words in a DEPTH-entry RAM with two compaction actions.
// ----------------------------------------------------------------------------
// One item is in work at a time; the input is ready only while the sequencer
// is idle, and a finished result sits in an output register so the next item
// can be taken while it waits. A push goes straight to the done state, a pop
// passes through one registered RAM read, and a compaction walks the n stored
// words: the walk reads one kept word per cycle and writes it back in the
// following cycle on the RAM's single write port. A push on a full stack is
// dropped with full_error; a pop on an empty stack returns 0 with empty_error.
// RAM contents are not cleared at reset; only entries below the fill count
// are ever read.
// ----------------------------------------------------------------------------
module lifo_stack_with_alternate_drop import lsad_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lsad_in_if.sink   i_in,
    lsad_out_if.source o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic              r_out_valid;
    t_result           r_out;

    lsad_core #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    lsad_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: loads when empty or when its word is being taken
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.popped_value  = r_out.popped_value;
    assign o_out.element_count = r_out.element_count;
    assign o_out.empty_error   = r_out.empty_error;
    assign o_out.full_error    = r_out.full_error;

endmodule
`default_nettype wire
